FILE: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key-value cache: field widths,
// operation codes, register map, controller states and the cell command.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int LKV_MAX_ENTRIES = 16;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = 5;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [CAP_W-1:0]         CAP_RESET    = 5'd16;
  localparam logic signed [VAL_W-1:0]  MISS_VALUE   = -32'sd1;
  localparam logic [PADDR_W-3:0]       REG_CAPACITY = 1'b0;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic look;
    logic update;
    logic hit;
    logic is_put;
    logic evict;
  } cell_cmd_t;

endpackage

FILE: rtl/lkv_in_if.sv
// ----------------------------------------------------------------------------
// lkv_in_if
// Request channel of the LRU key-value cache: one get or put per transaction.
// ----------------------------------------------------------------------------
interface lkv_in_if
  import lkv_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [KEY_W-1:0]  lookup_key;
  logic signed [VAL_W-1:0]  write_value;

  modport source (output valid, output opcode, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input opcode, input lookup_key, input write_value,
                  output ready);
endinterface

FILE: rtl/lkv_out_if.sv
// ----------------------------------------------------------------------------
// lkv_out_if
// Response channel of the LRU key-value cache: one result per request.
// ----------------------------------------------------------------------------
interface lkv_out_if
  import lkv_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [VAL_W-1:0]  read_value;
  logic                     evicted;
  logic signed [KEY_W-1:0]  evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

FILE: rtl/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// One cache slot: key, value and recency rank. Compares the broadcast key,
// passes the hit and victim data down the chain and applies the update.
// ----------------------------------------------------------------------------
module lkv_cell
  import lkv_pkg::*;
#(
  parameter int RANK_W = 4,
  parameter int CNT_W  = 5,
  parameter int INDEX  = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_cmd_t                cmd,
  input  logic signed [KEY_W-1:0]  key_in,
  input  logic signed [VAL_W-1:0]  value_in,
  input  logic [CNT_W-1:0]         count,
  input  logic [RANK_W-1:0]        hit_rank,
  input  logic                     hit_prev,
  input  logic signed [VAL_W-1:0]  value_prev,
  input  logic [RANK_W-1:0]        rank_prev,
  input  logic signed [KEY_W-1:0]  vkey_prev,
  output logic                     hit_next,
  output logic signed [VAL_W-1:0]  value_next,
  output logic [RANK_W-1:0]        rank_next,
  output logic signed [KEY_W-1:0]  vkey_next
);

  logic                     valid_r;
  logic signed [KEY_W-1:0]  key_r;
  logic signed [VAL_W-1:0]  value_r;
  logic [RANK_W-1:0]        rank_r;
  logic                     match_r;
  logic                     victim_r;

  logic                     match;
  logic                     victim;
  logic                     is_free;
  logic                     target;
  logic [CNT_W-1:0]         last;

  assign last    = count - CNT_W'(1);
  assign match   = valid_r && (key_r == key_in);
  assign victim  = valid_r && (rank_r == last[RANK_W-1:0]);
  assign is_free = (count == CNT_W'(INDEX));
  assign target  = cmd.evict ? victim_r : is_free;

  assign hit_next   = hit_prev | match;
  assign value_next = value_prev | (match ? value_r : '0);
  assign rank_next  = rank_prev | (match ? rank_r : '0);
  assign vkey_next  = vkey_prev | (victim ? key_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.update && !cmd.hit && cmd.is_put && target) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      match_r  <= match;
      victim_r <= victim;
    end
    if (cmd.update) begin
      if (cmd.hit) begin
        if (match_r) begin
          rank_r <= '0;
          if (cmd.is_put) begin
            value_r <= value_in;
          end
        end else if (valid_r && (rank_r < hit_rank)) begin
          rank_r <= rank_r + RANK_W'(1);
        end
      end else if (cmd.is_put) begin
        if (target) begin
          key_r   <= key_in;
          value_r <= value_in;
          rank_r  <= '0;
        end else if (valid_r) begin
          rank_r <= rank_r + RANK_W'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request goes through a lookup cycle, in which every cell compares
// its key with the request and the hit and victim data ripple down the row of
// cells, and an update cycle in which the recency ranks, the stored entry and
// the occupancy change; a new request is taken in that update cycle, so the
// cache takes a new request only once the last has reached its update. A result that is not
// taken holds the update cycle until the response register frees. The
// capacity register sits at byte address 0 of the configuration port.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = LKV_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  lkv_in_if.sink              in_chan,
  lkv_out_if.source           out_chan,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_t                   state_r, state_nxt;
  op_t                      op_r;
  logic signed [KEY_W-1:0]  key_r;
  logic signed [VAL_W-1:0]  wval_r;
  logic                     hit_r;
  logic signed [VAL_W-1:0]  hit_value_r;
  logic [RANK_W-1:0]        hit_rank_r;
  logic signed [KEY_W-1:0]  vkey_r;
  logic [CNT_W-1:0]         count_r;
  logic [CAP_W-1:0]         cap_r;

  logic                     out_valid_r;
  logic                     out_hit_r;
  logic signed [VAL_W-1:0]  out_value_r;
  logic                     out_evicted_r;
  logic signed [KEY_W-1:0]  out_vkey_r;

  cell_cmd_t                cmd;
  logic                     out_free;
  logic                     accept;
  logic                     evict;
  logic [CMP_W-1:0]         cap_ext;
  logic [CMP_W-1:0]         eff_cap;
  logic                     cfg_write;

  logic                     hit_ch   [MAX_ENTRIES+1];
  logic signed [VAL_W-1:0]  value_ch [MAX_ENTRIES+1];
  logic [RANK_W-1:0]        rank_ch  [MAX_ENTRIES+1];
  logic signed [KEY_W-1:0]  vkey_ch  [MAX_ENTRIES+1];

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict = (op_r == OP_PUT) && !hit_r && (CMP_W'(count_r) >= eff_cap);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) state_nxt = in_chan.valid ? ST_LOOK : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.hit        = hit_r;
    cmd.is_put     = (op_r == OP_PUT);
    cmd.evict      = evict;
    in_chan.ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
      end
      ST_UPD: begin
        cmd.update    = out_free;
        in_chan.ready = out_free;
      end
      default: begin
        in_chan.ready = 1'b0;
      end
    endcase
  end

  assign accept = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_chan.opcode);
      key_r  <= in_chan.lookup_key;
      wval_r <= in_chan.write_value;
    end
    if (cmd.look) begin
      hit_r       <= hit_ch[MAX_ENTRIES];
      hit_value_r <= value_ch[MAX_ENTRIES];
      hit_rank_r  <= rank_ch[MAX_ENTRIES];
      vkey_r      <= vkey_ch[MAX_ENTRIES];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.update && (op_r == OP_PUT) && !hit_r && !evict) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  assign hit_ch[0]   = 1'b0;
  assign value_ch[0] = '0;
  assign rank_ch[0]  = '0;
  assign vkey_ch[0]  = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .RANK_W (RANK_W),
      .CNT_W  (CNT_W),
      .INDEX  (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .key_in     (key_r),
      .value_in   (wval_r),
      .count      (count_r),
      .hit_rank   (hit_rank_r),
      .hit_prev   (hit_ch[i]),
      .value_prev (value_ch[i]),
      .rank_prev  (rank_ch[i]),
      .vkey_prev  (vkey_ch[i]),
      .hit_next   (hit_ch[i+1]),
      .value_next (value_ch[i+1]),
      .rank_next  (rank_ch[i+1]),
      .vkey_next  (vkey_ch[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r     <= hit_r;
      out_evicted_r <= evict;
      out_vkey_r    <= evict ? vkey_r : '0;
      if (op_r == OP_PUT) begin
        out_value_r <= '0;
      end else begin
        out_value_r <= hit_r ? hit_value_r : MISS_VALUE;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.read_value  = out_value_r;
  assign out_chan.evicted     = out_evicted_r;
  assign out_chan.evicted_key = out_vkey_r;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_write && (paddr[PADDR_W-1:2] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_CAPACITY) begin
      prdata = PDATA_W'(cap_r);
    end
  end

endmodule
